// File: design/spq_pkg.sv
// Package for the sorted priority queue: payload structs, cell data and
// control types, status and action codes. No dependencies.
`default_nettype none
package spq_pkg;

   localparam int unsigned CAPACITY = 16;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned PRIO_W   = 16;
   localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'b001,
      CELL_INSERT = 3'b010,
      CELL_REMOVE = 3'b100
   } cell_op_type;

   typedef struct packed {
      logic                      action;
      logic signed [VALUE_W-1:0] data_value;
      logic signed [PRIO_W-1:0]  priority_req;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic                      is_empty;
      logic signed [VALUE_W-1:0] head_value;
      logic signed [PRIO_W-1:0]  head_priority;
      logic [COUNT_W-1:0]        occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   fresh;
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: design/spq_cell.sv
// One slot of the sorted queue. Holds an entry, tells its right neighbor
// whether a new entry sorts behind it, and shifts on insert or removal.
// Depends on spq_pkg.
`default_nettype none
module spq_cell (
   input  wire logic                 clock,
   input  wire spq_pkg::cell_ctl_type ctl,
   input  wire logic                 occupied,
   input  wire logic                 left_after,
   input  wire spq_pkg::entry_type   left_entry,
   input  wire spq_pkg::entry_type   right_entry,
   output logic                      after,
   output spq_pkg::entry_type        entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // new entry goes behind this one when this slot is occupied and its priority is not larger
   assign after = occupied && (entry_ff.prio <= ctl.fresh.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         spq_pkg::CELL_HOLD: begin
            entry_in = entry_ff;
         end
         spq_pkg::CELL_INSERT: begin
            if (after) begin
               entry_in = entry_ff;
            end else if (left_after) begin
               entry_in = ctl.fresh;
            end else begin
               entry_in = left_entry;
            end
         end
         spq_pkg::CELL_REMOVE: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// File: design/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of spq_cell slots, the
// entry count and the result register. Depends on spq_pkg and spq_cell.
//
//   port group | direction | payload   | meaning
//   req_       | in        | req_type  | insert value/priority or remove head
//   rsp_       | out       | rsp_type  | status and queue head after the step
//
// One item per cycle unless stalled: every cell compares and shifts in parallel
// in the cycle the request transfer happens; the result is shown the cycle after.
// Reset clears the entry count and the result valid; slot contents are not reset.
// A stalled result holds the queue and stalls the request side; a new request
// is taken in the cycle the waiting result transfers.
`default_nettype none
module sorted_priority_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output spq_pkg::rsp_type      rsp_data
);

   localparam int unsigned N = spq_pkg::CAPACITY;

   logic                         rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type          status_ff, status_in;
   logic [spq_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic                         accept;
   logic                         is_full;
   logic                         is_none;
   spq_pkg::cell_ctl_type        ctl;
   logic [N-1:0]                 after;
   spq_pkg::entry_type           entry [N];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == spq_pkg::COUNT_W'(N));
   assign is_none   = (count_ff == '0);

   always_comb begin
      ctl.fresh.value = req_data.data_value;
      ctl.fresh.prio  = req_data.priority_req;
      ctl.op          = spq_pkg::CELL_HOLD;
      status_in       = status_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = spq_pkg::STATUS_OK;
         if (req_data.action == spq_pkg::ACTION_INSERT) begin
            if (is_full) begin
               status_in = spq_pkg::STATUS_FULL;
            end else begin
               ctl.op   = spq_pkg::CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_none) begin
               status_in = spq_pkg::STATUS_EMPTY;
            end else begin
               ctl.op   = spq_pkg::CELL_REMOVE;
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic               occupied;
      logic               left_after;
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;

      assign occupied = (spq_pkg::COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_after = 1'b0;
         assign left_entry = ctl.fresh;
      end else begin : g_rest
         assign left_after = after[i-1];
         assign left_entry = entry[i-1];
      end

      if (i == N - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_mid
         assign right_entry = entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied),
         .left_after  (left_after),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .after       (after[i]),
         .entry       (entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= spq_pkg::STATUS_OK;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.status        = status_ff;
   assign rsp_data.is_empty      = is_none;
   assign rsp_data.head_value    = is_none ? '0 : entry[0].value;
   assign rsp_data.head_priority = is_none ? '0 : entry[0].prio;
   assign rsp_data.occupancy     = count_ff;

endmodule
`default_nettype wire

// File: design/spq_checker.sv
// Port-level checks for sorted_priority_queue, attached by bind.
// Depends on spq_pkg.
`default_nettype none
module spq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire spq_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire spq_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.occupancy == '0)))
      else $error("empty flag and occupancy disagree");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         rsp_data.head_value == '0 && rsp_data.head_priority == '0)
      else $error("empty queue shows nonzero head");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spq_pkg::STATUS_FULL |->
         rsp_data.occupancy == spq_pkg::COUNT_W'(spq_pkg::CAPACITY))
      else $error("drop reported while not full");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && rsp_valid &&
      req_data.action == spq_pkg::ACTION_INSERT &&
      rsp_data.occupancy != spq_pkg::COUNT_W'(spq_pkg::CAPACITY) |=>
         rsp_data.occupancy == $past(rsp_data.occupancy) + 1'b1)
      else $error("insert did not grow the queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
